@@ rtl/assert_macros.svh @@
// assertion macros used by the top level to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rlcs_pkg.sv @@
// types, constants and microcode table of the range letter count and sort core
package rlcs_pkg;

  localparam int STORE_DEPTH   = 1024;
  localparam int ALPHABET_SIZE = 26;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 10;
  localparam int SYM_W    = 5;
  localparam int LETTER_W = 5;
  localparam int CNT_W    = 11;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int PTR_W    = (ADDR_W > POS_W) ? ADDR_W : POS_W;
  localparam int STEP_W   = 4;

  localparam logic [SYM_W-1:0]    EMPTY_CODE  = '1;
  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET_SIZE - 1);
  localparam logic [CNT_W-1:0]    COUNT_MAX   = '1;
  localparam logic [PTR_W-1:0]    LAST_PTR    = PTR_W'(STORE_DEPTH - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_SORT  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STEP_W-1:0] {
    S_IDLE      = 4'd0,
    S_WRITE     = 4'd1,
    S_SETUP     = 4'd2,
    S_SCAN      = 4'd3,
    S_DRAIN     = 4'd4,
    S_LOAD      = 4'd5,
    S_RUN       = 4'd6,
    S_NEXT      = 4'd7,
    S_DONE      = 4'd8,
    S_EMIT      = 4'd9,
    S_FIN       = 4'd10,
    S_CLR       = 4'd11,
    S_CLR_END   = 4'd12,
    S_RST_SWEEP = 4'd13,
    S_RST_END   = 4'd14
  } step_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_SCAN_MORE,
    C_RANGE_BAD,
    C_IS_COUNT,
    C_CNT_ZERO,
    C_REM_MORE,
    C_LETTER_MORE,
    C_PTR_NOT_LAST
  } cond_t;

  typedef enum logic {ADDR_PTR, ADDR_LO} addr_sel_t;
  typedef enum logic [1:0] {WD_NONE, WD_SYM, WD_LETTER, WD_EMPTY} wdata_sel_t;
  typedef enum logic [1:0] {PTR_HOLD, PTR_ZERO, PTR_LO, PTR_INC} ptr_op_t;
  typedef enum logic [1:0] {LET_HOLD, LET_ZERO, LET_INC} letter_op_t;
  typedef enum logic [1:0] {REM_HOLD, REM_LOAD, REM_DEC} rem_op_t;
  typedef enum logic [1:0] {EMIT_NONE, EMIT_COUNT, EMIT_DONE} emit_op_t;

  typedef struct packed {
    logic       wait_in;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    logic       ram_rd;
    ptr_op_t    ptr_op;
    letter_op_t letter_op;
    rem_op_t    rem_op;
    logic       cnt_clr;
    emit_op_t   emit_op;
    cond_t      cond;
    step_t      target;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   adv;
    logic   accept;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic scan_more;
    logic range_bad;
    logic is_count;
    logic cnt_zero;
    logic rem_more;
    logic letter_more;
    logic ptr_not_last;
  } stat_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] left_pos;
    logic [POS_W-1:0] right_pos;
    logic [SYM_W-1:0] symbol;
  } item_t;

  typedef struct packed {
    logic                kind;
    logic [LETTER_W-1:0] letter;
    logic [CNT_W-1:0]    letter_count;
    logic                last;
  } result_t;

  localparam uword_t UW_NOP = '{
    wait_in:   1'b0,
    addr_sel:  ADDR_PTR,
    wdata_sel: WD_NONE,
    ram_rd:    1'b0,
    ptr_op:    PTR_HOLD,
    letter_op: LET_HOLD,
    rem_op:    REM_HOLD,
    cnt_clr:   1'b0,
    emit_op:   EMIT_NONE,
    cond:      C_NEVER,
    target:    S_IDLE
  };

  // microprogram: one control word per step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = UW_NOP;
    unique case (s)
      S_IDLE: begin
        w.wait_in = 1'b1;
        w.ptr_op  = PTR_ZERO;
        w.cond    = C_DISPATCH;
      end
      S_WRITE: begin
        w.addr_sel  = ADDR_LO;
        w.wdata_sel = WD_SYM;
        w.cond      = C_ALWAYS;
        w.target    = S_IDLE;
      end
      S_SETUP: begin
        w.cnt_clr   = 1'b1;
        w.ptr_op    = PTR_LO;
        w.letter_op = LET_ZERO;
        w.cond      = C_RANGE_BAD;
        w.target    = S_DRAIN;
      end
      S_SCAN: begin
        w.ram_rd = 1'b1;
        w.ptr_op = PTR_INC;
        w.cond   = C_SCAN_MORE;
        w.target = S_SCAN;
      end
      S_DRAIN: begin
        w.ptr_op = PTR_LO;
        w.cond   = C_IS_COUNT;
        w.target = S_EMIT;
      end
      S_LOAD: begin
        w.rem_op = REM_LOAD;
        w.cond   = C_CNT_ZERO;
        w.target = S_NEXT;
      end
      S_RUN: begin
        w.wdata_sel = WD_LETTER;
        w.ptr_op    = PTR_INC;
        w.rem_op    = REM_DEC;
        w.cond      = C_REM_MORE;
        w.target    = S_RUN;
      end
      S_NEXT: begin
        w.letter_op = LET_INC;
        w.cond      = C_LETTER_MORE;
        w.target    = S_LOAD;
      end
      S_DONE: begin
        w.emit_op = EMIT_DONE;
        w.cond    = C_ALWAYS;
        w.target  = S_IDLE;
      end
      S_EMIT: begin
        w.emit_op   = EMIT_COUNT;
        w.letter_op = LET_INC;
        w.cond      = C_LETTER_MORE;
        w.target    = S_EMIT;
      end
      S_FIN: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_CLR: begin
        w.wdata_sel = WD_EMPTY;
        w.ptr_op    = PTR_INC;
        w.cond      = C_PTR_NOT_LAST;
        w.target    = S_CLR;
      end
      S_CLR_END: begin
        w.cond   = C_ALWAYS;
        w.target = S_DONE;
      end
      S_RST_SWEEP: begin
        w.wdata_sel = WD_EMPTY;
        w.ptr_op    = PTR_INC;
        w.cond      = C_PTR_NOT_LAST;
        w.target    = S_RST_SWEEP;
      end
      S_RST_END: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // entry step of each command
  function automatic step_t dispatch(logic [CMD_W-1:0] c);
    step_t s;
    s = S_IDLE;
    unique case (cmd_t'(c))
      CMD_WRITE: s = S_WRITE;
      CMD_COUNT: s = S_SETUP;
      CMD_SORT:  s = S_SETUP;
      CMD_CLEAR: s = S_CLR;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/rlcs_if.sv @@
// valid/ready channel interfaces for commands and results
interface rlcs_cmd_if;
  import rlcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [POS_W-1:0]    left_pos;
  logic [POS_W-1:0]    right_pos;
  logic [SYM_W-1:0]    symbol;

  modport source (output valid, command, left_pos, right_pos, symbol, input ready);
  modport sink (input valid, command, left_pos, right_pos, symbol, output ready);
endinterface

interface rlcs_res_if;
  import rlcs_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [LETTER_W-1:0] letter;
  logic [CNT_W-1:0]    letter_count;
  logic                last;

  modport source (output valid, kind, letter, letter_count, last, input ready);
  modport sink (input valid, kind, letter, letter_count, last, output ready);
endinterface

@@ rtl/rlcs_ram.sv @@
// generic single-port ram with registered read
module rlcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

@@ rtl/rlcs_seq.sv @@
// microcode sequencer: step counter, control rom and jump logic
module rlcs_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [rlcs_pkg::CMD_W-1:0] command,
  input  rlcs_pkg::stat_t            stat,
  output rlcs_pkg::ctrl_t            ctrl
);
  import rlcs_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   adv;
  logic   cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_RST_SWEEP;
    end else begin
      step <= step_next;
    end
  end

  // control outputs
  always_comb begin
    uw  = ucode(step);
    adv = !(uw.wait_in && !in_valid) && !((uw.emit_op != EMIT_NONE) && !stat.out_free);
    ctrl.uw     = uw;
    ctrl.adv    = adv;
    ctrl.accept = uw.wait_in && in_valid;
  end

  // next step
  always_comb begin
    unique case (uw.cond)
      C_NEVER:        cond_true = 1'b0;
      C_ALWAYS:       cond_true = 1'b1;
      C_DISPATCH:     cond_true = 1'b1;
      C_SCAN_MORE:    cond_true = stat.scan_more;
      C_RANGE_BAD:    cond_true = stat.range_bad;
      C_IS_COUNT:     cond_true = stat.is_count;
      C_CNT_ZERO:     cond_true = stat.cnt_zero;
      C_REM_MORE:     cond_true = stat.rem_more;
      C_LETTER_MORE:  cond_true = stat.letter_more;
      C_PTR_NOT_LAST: cond_true = stat.ptr_not_last;
      default:        cond_true = 1'b1;
    endcase

    priority if (!adv) begin
      step_next = step;
    end else if (cond_true && (uw.cond == C_DISPATCH)) begin
      step_next = dispatch(command);
    end else if (cond_true) begin
      step_next = uw.target;
    end else begin
      step_next = step_t'(step + STEP_W'(1));
    end
  end
endmodule

@@ rtl/rlcs_dp.sv @@
// datapath: command registers, pointers, letter counters, symbol store, result register
module rlcs_dp (
  input  logic              clk,
  input  logic              rst,
  input  rlcs_pkg::ctrl_t   ctrl,
  input  rlcs_pkg::item_t   item,
  output rlcs_pkg::stat_t   stat,
  output rlcs_pkg::result_t res_data,
  output logic              res_valid,
  input  logic              res_ready
);
  import rlcs_pkg::*;

  logic [CMD_W-1:0]    cmd_r;
  logic [POS_W-1:0]    lo_r;
  logic [POS_W-1:0]    hi_r;
  logic [SYM_W-1:0]    sym_r;
  logic [PTR_W-1:0]    ptr;
  logic [LETTER_W-1:0] letter;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    counts [ALPHABET_SIZE];
  logic                acc_en;

  logic [PTR_W-1:0]    lo_ext;
  logic [PTR_W-1:0]    hi_ext;
  logic [PTR_W-1:0]    hi_eff;
  logic [LETTER_W-1:0] cnt_idx;
  logic [CNT_W-1:0]    cnt_sel;
  logic                acc_ok;
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SYM_W-1:0]    ram_wdata;
  logic [SYM_W-1:0]    ram_rdata;
  logic                emit;

  assign lo_ext = PTR_W'(lo_r);
  assign hi_ext = PTR_W'(hi_r);
  assign hi_eff = (hi_ext > LAST_PTR) ? LAST_PTR : hi_ext;

  // counter file has a single read port: the store data while counting, else the letter
  assign cnt_idx = acc_en ? ram_rdata : letter;
  assign cnt_sel = (cnt_idx < LETTER_W'(ALPHABET_SIZE)) ? counts[cnt_idx] : '0;
  assign acc_ok  = acc_en && (ram_rdata < SYM_W'(ALPHABET_SIZE)) && (cnt_sel != COUNT_MAX);

  always_comb begin
    stat.out_free     = !res_valid || res_ready;
    stat.scan_more    = ptr != hi_eff;
    stat.range_bad    = (lo_ext > hi_ext) || (lo_ext > LAST_PTR);
    stat.is_count     = cmd_t'(cmd_r) == CMD_COUNT;
    stat.cnt_zero     = cnt_sel == '0;
    stat.rem_more     = rem != CNT_W'(1);
    stat.letter_more  = letter != LAST_LETTER;
    stat.ptr_not_last = ptr != LAST_PTR;
  end

  // store port
  always_comb begin
    ram_addr = (ctrl.uw.addr_sel == ADDR_LO) ? ADDR_W'(lo_ext) : ptr[ADDR_W-1:0];
    ram_re   = ctrl.adv && ctrl.uw.ram_rd;
    unique case (ctrl.uw.wdata_sel)
      WD_NONE: begin
        ram_we    = 1'b0;
        ram_wdata = EMPTY_CODE;
      end
      WD_SYM: begin
        // non-letter symbols and positions past the store are dropped
        ram_we    = ctrl.adv && (sym_r < SYM_W'(ALPHABET_SIZE)) && (lo_ext <= LAST_PTR);
        ram_wdata = sym_r;
      end
      WD_LETTER: begin
        ram_we    = ctrl.adv;
        ram_wdata = SYM_W'(letter);
      end
      WD_EMPTY: begin
        ram_we    = ctrl.adv;
        ram_wdata = EMPTY_CODE;
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = EMPTY_CODE;
      end
    endcase
  end

  rlcs_ram #(
    .WIDTH(SYM_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_r <= item.command;
      lo_r  <= item.left_pos;
      hi_r  <= item.right_pos;
      sym_r <= item.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      acc_en <= 1'b0;
    end else begin
      acc_en <= ram_re;
      if (ctrl.adv) begin
        unique case (ctrl.uw.ptr_op)
          PTR_HOLD: ptr <= ptr;
          PTR_ZERO: ptr <= '0;
          PTR_LO:   ptr <= lo_ext;
          PTR_INC:  ptr <= ptr + PTR_W'(1);
          default:  ptr <= ptr;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      unique case (ctrl.uw.letter_op)
        LET_HOLD: letter <= letter;
        LET_ZERO: letter <= '0;
        LET_INC:  letter <= letter + LETTER_W'(1);
        default:  letter <= letter;
      endcase
      unique case (ctrl.uw.rem_op)
        REM_HOLD: rem <= rem;
        REM_LOAD: rem <= cnt_sel;
        REM_DEC:  rem <= rem - CNT_W'(1);
        default:  rem <= rem;
      endcase
    end
  end

  // letter counters: cleared at the start of each count or sort, at most one increment per store read
  always_ff @(posedge clk) begin
    if (ctrl.adv && ctrl.uw.cnt_clr) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        counts[i] <= '0;
      end
    end else if (acc_ok) begin
      counts[cnt_idx] <= cnt_sel + CNT_W'(1);
    end
  end

  // result register
  assign emit = ctrl.adv && (ctrl.uw.emit_op != EMIT_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctrl.uw.emit_op == EMIT_COUNT) begin
        res_data.kind         <= 1'b0;
        res_data.letter       <= letter;
        res_data.letter_count <= cnt_sel;
        res_data.last         <= letter == LAST_LETTER;
      end else begin
        res_data.kind         <= 1'b1;
        res_data.letter       <= '0;
        res_data.letter_count <= '0;
        res_data.last         <= 1'b1;
      end
    end
  end
endmodule

@@ rtl/range_letter_count_and_sort_core.sv @@
// top level of the range letter count and sort core
//
//  channel | role   | payload                                  | transfer
//  cmd     | sink   | command, left_pos, right_pos, symbol     | valid && ready
//  res     | source | kind, letter, letter_count, last         | valid && ready
//
// one command at a time; the single-port symbol store is the limit
// write: store write; count: scan, result per letter; sort: scan, rewrite, done result
// clear: sweep, done result; after reset a sweep empties the store, cmd.ready stays low
// results sit in one output register, so a new command is taken while the last result waits
// a stalled result freezes the sequencer on its emitting step
`include "assert_macros.svh"

module range_letter_count_and_sort_core (
  input logic       clk,
  input logic       rst,
  rlcs_cmd_if.sink  cmd,
  rlcs_res_if.source res
);
  import rlcs_pkg::*;

  ctrl_t   ctrl;
  stat_t   stat;
  item_t   item;
  result_t res_data;

  assign item.command   = cmd.command;
  assign item.left_pos  = cmd.left_pos;
  assign item.right_pos = cmd.right_pos;
  assign item.symbol    = cmd.symbol;
  assign cmd.ready      = ctrl.uw.wait_in;

  rlcs_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(cmd.valid),
    .command (cmd.command),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  rlcs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .item     (item),
    .stat     (stat),
    .res_data (res_data),
    .res_valid(res.valid),
    .res_ready(res.ready)
  );

  assign res.kind         = res_data.kind;
  assign res.letter       = res_data.letter;
  assign res.letter_count = res_data.letter_count;
  assign res.last         = res_data.last;

  `ASSERT_NEXT(a_busy_after_take, cmd.valid && cmd.ready, !cmd.ready, "command taken while busy")
  `ASSERT_IMPLIES(a_last_count, res.valid && res.last && !res.kind, res.letter == LAST_LETTER, "count ends early")
  `ASSERT_IMPLIES(a_done_shape, res.valid && res.kind, res.last && (res.letter == '0) && (res.letter_count == '0), "bad done result")
endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the range letter count and sort core
module tb_top;
  import rlcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 2200;
  localparam int RANDOM_ITEMS = 290;
  localparam int CALM_TAIL    = 40;

  // tracks the symbol store and holds the results still owed by the core
  class letter_tally_board;
    logic [SYM_W-1:0] sym_mem [STORE_DEPTH];
    result_t          owed_q [$];
    int               errors;

    function new();
      errors = 0;
      wipe_store();
    endfunction

    function void wipe_store();
      foreach (sym_mem[i]) sym_mem[i] = EMPTY_CODE;
    endfunction

    function void note_command(item_t it);
      int      tally [ALPHABET_SIZE];
      int      lo;
      int      hi;
      int      pos;
      result_t r;
      lo = int'(it.left_pos);
      hi = int'(it.right_pos);
      foreach (tally[i]) tally[i] = 0;
      case (cmd_t'(it.command))
        CMD_WRITE: begin
          if (it.symbol < ALPHABET_SIZE && lo < STORE_DEPTH) sym_mem[lo] = it.symbol;
        end
        CMD_COUNT, CMD_SORT: begin
          if (lo <= hi && lo < STORE_DEPTH) begin
            if (hi >= STORE_DEPTH) hi = STORE_DEPTH - 1;
            for (int p = lo; p <= hi; p++)
              if (sym_mem[p] < ALPHABET_SIZE) tally[sym_mem[p]]++;
          end
          if (cmd_t'(it.command) == CMD_COUNT) begin
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
              r.kind         = 1'b0;
              r.letter       = LETTER_W'(i);
              r.letter_count = (tally[i] > COUNT_MAX) ? COUNT_MAX : CNT_W'(tally[i]);
              r.last         = (i == ALPHABET_SIZE - 1);
              owed_q = {owed_q, r};
            end
          end else begin
            // letters go back in ascending order from the left end
            pos = lo;
            for (int i = 0; i < ALPHABET_SIZE; i++)
              for (int n = 0; n < tally[i]; n++) begin
                if (pos < STORE_DEPTH) sym_mem[pos] = SYM_W'(i);
                pos++;
              end
            r = '{kind: 1'b1, letter: '0, letter_count: '0, last: 1'b1};
            owed_q = {owed_q, r};
          end
        end
        CMD_CLEAR: begin
          wipe_store();
          r = '{kind: 1'b1, letter: '0, letter_count: '0, last: 1'b1};
          owed_q = {owed_q, r};
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: kind %0d letter %0d letter_count %0d last %0d",
               got.kind, got.letter, got.letter_count, got.last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("letter", 32'(want.letter), 32'(got.letter));
      compare_field("letter_count", 32'(want.letter_count), 32'(got.letter_count));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rlcs_cmd_if cmd_ch ();
  rlcs_res_if res_ch ();

  range_letter_count_and_sort_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  letter_tally_board board = new();
  bit idle_on = 1'b1;
  int items_sent = 0;
  int cycles = 0;
  int stall_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.kind         = res_ch.kind;
      got.letter       = res_ch.letter;
      got.letter_count = res_ch.letter_count;
      got.last         = res_ch.last;
      board.check_result(got);
    end
  end

  // result side back-pressure in bursts
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_cmd(input cmd_t op, input int lo, input int hi, input int sym);
    item_t it;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    it.command   = op;
    it.left_pos  = POS_W'(lo);
    it.right_pos = POS_W'(hi);
    it.symbol    = SYM_W'(sym);
    cmd_ch.command   = it.command;
    cmd_ch.left_pos  = it.left_pos;
    cmd_ch.right_pos = it.right_pos;
    cmd_ch.symbol    = it.symbol;
    cmd_ch.valid     = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    board.note_command(it);
    if (!(op == CMD_WRITE && sym >= ALPHABET_SIZE)) items_sent++;
    @(negedge clk);
  endtask

  task automatic window_sequence();
    int roll;
    int span;
    int base;
    int lo;
    int hi;
    int sym;
    cmd_t op;
    roll = $urandom_range(0, 99);
    if (roll < 85) span = $urandom_range(0, 31);
    else if (roll < 96) span = $urandom_range(32, 255);
    else span = STORE_DEPTH - 1;
    base = $urandom_range(0, STORE_DEPTH - 1 - span);
    repeat ($urandom_range(1, 8)) begin
      sym = ($urandom_range(0, 9) == 0) ? $urandom_range(ALPHABET_SIZE, 31)
                                        : $urandom_range(0, ALPHABET_SIZE - 1);
      send_cmd(CMD_WRITE, base + $urandom_range(0, span), $urandom_range(0, 1023), sym);
    end
    lo = base;
    hi = base + span;
    // now and then a reversed range
    if (span > 0 && $urandom_range(0, 9) == 0) begin
      lo = base + span;
      hi = base;
    end
    op = $urandom_range(0, 1) ? CMD_SORT : CMD_COUNT;
    send_cmd(op, lo, hi, $urandom_range(0, 31));
    if (op == CMD_SORT && $urandom_range(0, 1))
      send_cmd(CMD_COUNT, base, base + span, $urandom_range(0, 31));
  endtask

  task automatic noise_item();
    int roll;
    cmd_t op;
    roll = $urandom_range(0, 99);
    if (roll < 50) op = CMD_WRITE;
    else if (roll < 70) op = CMD_COUNT;
    else if (roll < 90) op = CMD_SORT;
    else op = CMD_CLEAR;
    send_cmd(op, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 31));
  endtask

  initial begin
    int goal;
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CMD_WRITE;
    cmd_ch.left_pos  = '0;
    cmd_ch.right_pos = '0;
    cmd_ch.symbol    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fresh store counts nothing
    send_cmd(CMD_COUNT, 0, 1023, 0);
    send_cmd(CMD_WRITE, 0, 0, 0);
    send_cmd(CMD_WRITE, 1023, 1023, 25);
    // non-letter symbols are dropped
    send_cmd(CMD_WRITE, 512, 0, 31);
    send_cmd(CMD_WRITE, 513, 0, 26);
    send_cmd(CMD_COUNT, 0, 1023, 31);
    send_cmd(CMD_COUNT, 1023, 0, 0);
    // sort across gaps; the tail past the letter total keeps old contents
    send_cmd(CMD_WRITE, 10, 0, 3);
    send_cmd(CMD_WRITE, 11, 0, 1);
    send_cmd(CMD_WRITE, 12, 0, 3);
    send_cmd(CMD_WRITE, 14, 0, 0);
    send_cmd(CMD_WRITE, 16, 0, 2);
    send_cmd(CMD_WRITE, 17, 0, 25);
    send_cmd(CMD_SORT, 10, 16, 0);
    send_cmd(CMD_COUNT, 10, 17, 0);
    send_cmd(CMD_COUNT, 16, 16, 0);
    send_cmd(CMD_SORT, 20, 10, 0);
    send_cmd(CMD_COUNT, 0, 0, 0);
    send_cmd(CMD_SORT, 0, 1023, 0);
    send_cmd(CMD_COUNT, 0, 20, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0);
    send_cmd(CMD_COUNT, 0, 1023, 0);

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if (items_sent >= goal - CALM_TAIL) idle_on = 1'b0;
      else if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 99) < 72) window_sequence();
      else noise_item();
    end
    idle_on = 1'b0;
    cmd_ch.valid = 1'b0;

    while (board.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rlcs_pkg.sv
rtl/rlcs_if.sv
rtl/rlcs_ram.sv
rtl/rlcs_seq.sv
rtl/rlcs_dp.sv
rtl/range_letter_count_and_sort_core.sv
tb/tb_top.sv
